[src/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared widths and the side-band record carried along the force pipeline.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int DW  = 33;   // |first - second| per axis
    localparam int SW  = 66;   // sum of squares
    localparam int RW  = 34;   // integer square root
    localparam int QW  = 64;   // scale numerator and quotient
    localparam int CW  = 31;   // configuration register width
    localparam int SCW = 49;   // clamped scale
    localparam int PW  = 82;   // dmag * clamped scale

    typedef struct packed {
        logic [2:0][DW-1:0] dmag;
        logic [2:0]         dneg;
        logic               contact;
        logic               interact;
        logic               zero;
        logic               sneg;
    } side_t;

endpackage

[src/spf_front.sv]
// ----------------------------------------------------------------------------
// spf_front
// Difference vector, squares and sum of squares, contact range test.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic              req_type,
    input  logic [2:0][31:0]  first_pos,
    input  logic [2:0][31:0]  second_pos,
    input  logic [CW-1:0]     contact_cutoff,
    output logic              out_valid,
    output logic [SW-1:0]     sum_sq,
    output side_t             side
);

    logic [2:0][DW-1:0] a_dmag_reg;
    logic [2:0]         a_dneg_reg;
    logic               a_contact_reg;
    logic               a_valid_reg;
    logic [2:0][SW-1:0] b_sq_reg;
    logic [2:0][DW-1:0] b_dmag_reg;
    logic [2:0]         b_dneg_reg;
    logic               b_contact_reg;
    logic               b_valid_reg;
    logic [2*CW-1:0]    c2_reg;
    logic [SW-1:0]      sum_reg;
    side_t              side_reg;
    logic               c_valid_reg;

    logic [2:0][DW-1:0] dmag_next;
    logic [2:0]         dneg_next;
    logic [SW-1:0]      sum_next;
    side_t              side_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [DW-1:0] d;
            d = $signed({first_pos[i][31], first_pos[i]})
              - $signed({second_pos[i][31], second_pos[i]});
            dneg_next[i] = d[DW-1];
            dmag_next[i] = d[DW-1] ? (~d + 1'b1) : d;
        end
    end

    always_comb
    begin
        sum_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        side_next.dmag     = b_dmag_reg;
        side_next.dneg     = b_dneg_reg;
        side_next.contact  = b_contact_reg;
        side_next.interact = !b_contact_reg || (sum_next < {{(SW-2*CW){1'b0}}, c2_reg});
        side_next.zero     = (sum_next == '0);
        side_next.sneg     = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        c2_reg <= {{CW{1'b0}}, contact_cutoff} * {{CW{1'b0}}, contact_cutoff};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dmag_reg    <= dmag_next;
            a_dneg_reg    <= dneg_next;
            a_contact_reg <= req_type;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= {{(SW-DW){1'b0}}, a_dmag_reg[i]}
                             * {{(SW-DW){1'b0}}, a_dmag_reg[i]};
            end
            b_dmag_reg    <= a_dmag_reg;
            b_dneg_reg    <= a_dneg_reg;
            b_contact_reg <= a_contact_reg;
            sum_reg       <= sum_next;
            side_reg      <= side_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign sum_sq    = sum_reg;
    assign side      = side_reg;

endmodule

[src/spf_isqrt.sv]
// ----------------------------------------------------------------------------
// spf_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module spf_isqrt
    import spf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [SW-1:0]  radicand,
    input  side_t          in_side,
    output logic           out_valid,
    output logic [RW-1:0]  root,
    output side_t          out_side
);

    localparam int N   = RW;
    localparam int SPW = 2 * RW;
    localparam int RMW = RW + 4;

    logic [N:0]     vld_reg;
    logic [SPW-1:0] sb_reg   [N+1];
    logic [RMW-1:0] rem_reg  [N+1];
    logic [RW-1:0]  root_reg [N+1];
    side_t          sd_reg   [N+1];

    always_comb
    begin
        vld_reg[0]  = in_valid;
        sb_reg[0]   = {{(SPW-SW){1'b0}}, radicand};
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        sd_reg[0]   = in_side;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb
        begin
            rem_t = {rem_reg[i][RMW-3:0], sb_reg[i][SPW-1:SPW-2]};
            trial = {2'b00, root_reg[i], 2'b01};
            ge    = (rem_t >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= ge ? (rem_t - trial) : rem_t;
                root_reg[i+1] <= {root_reg[i][RW-2:0], ge};
                sb_reg[i+1]   <= {sb_reg[i][SPW-3:0], 2'b00};
                sd_reg[i+1]   <= sd_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign root      = root_reg[N];
    assign out_side  = sd_reg[N];

endmodule

[src/spf_div.sv]
// ----------------------------------------------------------------------------
// spf_div
// Scale numerator k*|r - L| and a pipelined restoring divide by r.
// ----------------------------------------------------------------------------
module spf_div
    import spf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [RW-1:0]  root,
    input  logic [CW-1:0]  stiffness,
    input  logic [CW-1:0]  length,
    input  side_t          in_side,
    output logic           out_valid,
    output logic [QW-1:0]  quotient,
    output side_t          out_side
);

    localparam int N = QW;

    logic [N:0]     vld_reg;
    logic [QW-1:0]  w_reg   [N+1];
    logic [RW-1:0]  rem_reg [N+1];
    logic [RW-1:0]  dv_reg  [N+1];
    side_t          sd_reg  [N+1];

    logic           sneg;
    logic [RW-1:0]  len_ext;
    logic [RW-1:0]  smag;
    logic [QW:0]    num;
    side_t          side0;

    always_comb
    begin
        len_ext = {{(RW-CW){1'b0}}, length};
        sneg    = (root < len_ext);
        smag    = sneg ? (len_ext - root) : (root - len_ext);
        num     = {{(QW+1-CW){1'b0}}, stiffness} * {{(QW+1-RW){1'b0}}, smag};
        side0   = in_side;
        side0.sneg = sneg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg[0]   <= num[QW-1:0];
            rem_reg[0] <= '0;
            dv_reg[0]  <= root;
            sd_reg[0]  <= side0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [RW:0] t;
        logic        ge;

        always_comb
        begin
            t  = {rem_reg[i], w_reg[i][QW-1]};
            ge = (t >= {1'b0, dv_reg[i]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? RW'(t - {1'b0, dv_reg[i]}) : t[RW-1:0];
                w_reg[i+1]   <= {w_reg[i][QW-2:0], ge};
                dv_reg[i+1]  <= dv_reg[i];
                sd_reg[i+1]  <= sd_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign quotient  = w_reg[N];
    assign out_side  = sd_reg[N];

endmodule

[src/spf_back.sv]
// ----------------------------------------------------------------------------
// spf_back
// Scale clamp, split multiply d*scale, saturation and the output register.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [QW-1:0]     scale,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [2:0][31:0]  force_out,
    output logic              applied,
    output logic              coincident,
    output logic              saturated
);

    localparam int LOW = 25;

    logic [SCW-1:0] sc;
    logic [2:0][DW+LOW-1:0]     pl_reg;
    logic [2:0][DW+SCW-LOW-1:0] ph_reg;
    side_t          s1_reg;
    logic [2:0][PW-1:0] prod_reg;
    side_t          s2_reg;
    logic [2:0][31:0] force_reg;
    logic           applied_reg;
    logic           coincident_reg;
    logic           saturated_reg;
    logic [2:0]     vld_reg;

    logic [2:0][31:0] force_next;
    logic             sat_next;

    always_comb
    begin
        sc = (|scale[QW-1:SCW-1]) ? {1'b1, {(SCW-1){1'b0}}} : {1'b0, scale[SCW-2:0]};
    end

    always_comb
    begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            logic [PW-17:0] q;
            logic           neg;
            q   = prod_reg[i][PW-1:16];
            neg = (s2_reg.dneg[i] != s2_reg.sneg) && (q != '0);
            if (neg)
            begin
                if (q > {{(PW-48){1'b0}}, 32'h8000_0000})
                begin
                    force_next[i] = 32'h8000_0000;
                    sat_next      = 1'b1;
                end
                else
                begin
                    force_next[i] = 32'd0 - q[31:0];
                end
            end
            else
            begin
                if (q > {{(PW-48){1'b0}}, 32'h7FFF_FFFF})
                begin
                    force_next[i] = 32'h7FFF_FFFF;
                    sat_next      = 1'b1;
                end
                else
                begin
                    force_next[i] = q[31:0];
                end
            end
        end
        if (!s2_reg.interact || s2_reg.zero)
        begin
            force_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= {{LOW{1'b0}}, in_side.dmag[i]}
                           * {{DW{1'b0}}, sc[LOW-1:0]};
                ph_reg[i] <= {{(SCW-LOW){1'b0}}, in_side.dmag[i]}
                           * {{DW{1'b0}}, sc[SCW-1:LOW]};
                prod_reg[i] <= {{(PW-DW-LOW){1'b0}}, pl_reg[i]}
                             + ({{(PW-DW-SCW+LOW){1'b0}}, ph_reg[i]} << LOW);
            end
            s1_reg         <= in_side;
            s2_reg         <= s1_reg;
            force_reg      <= force_next;
            saturated_reg  <= sat_next;
            applied_reg    <= s2_reg.interact && !s2_reg.zero;
            coincident_reg <= s2_reg.interact && s2_reg.zero;
        end
    end

    assign out_valid  = vld_reg[2];
    assign force_out  = force_reg;
    assign applied    = applied_reg;
    assign coincident = coincident_reg;
    assign saturated  = saturated_reg;

endmodule

[src/spring_pair_force_unit.sv]
// ----------------------------------------------------------------------------
// spring_pair_force_unit
// Spring or hard-core contact force between two beads, Q16.16, pipelined.
// ----------------------------------------------------------------------------
// Input channel s_*: tdata holds first_x/y/z and second_x/y/z, tuser the pair
// kind (0 bond, 1 contact). Output channel m_*: tdata holds force_x/y/z on
// the second bead, tuser the applied, coincident and saturated flags.
// Registers are written on cfg_we with cfg_index 0..3; the user must do so
// only while the unit is idle; the block does not enforce it. Throughput is
// one item per cycle. Stages: 3 front, 34 square root (one root bit each), 65
// divide (scale numerator plus one quotient bit each), 3 multiply/saturate.
// The whole pipeline advances on one enable; when m_tready is low with a
// result waiting, every stage holds and s_tready drops, so no item is lost
// or repeated. Reset empties the pipeline and loads the default registers.
// ----------------------------------------------------------------------------
module spring_pair_force_unit
    import spf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic          s_tuser,   // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // force_x, force_y, force_z
    output logic [2:0]    m_tuser,   // applied, coincident, saturated
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data
);

    typedef enum logic [1:0] {
        REG_BOND_REST    = 2'd0,
        REG_BOND_STIFF   = 2'd1,
        REG_CONT_CUTOFF  = 2'd2,
        REG_CONT_STIFF   = 2'd3
    } cfg_reg_t;

    logic [CW-1:0] bond_rest_reg;
    logic [CW-1:0] bond_stiff_reg;
    logic [CW-1:0] cont_cutoff_reg;
    logic [CW-1:0] cont_stiff_reg;

    logic              en;
    logic [2:0][31:0]  first_pos;
    logic [2:0][31:0]  second_pos;
    logic              f_valid;
    logic [SW-1:0]     f_sum;
    side_t             f_side;
    logic              r_valid;
    logic [RW-1:0]     r_root;
    side_t             r_side;
    logic [CW-1:0]     sel_k;
    logic [CW-1:0]     sel_len;
    logic              d_valid;
    logic [QW-1:0]     d_quot;
    side_t             d_side;
    logic [2:0][31:0]  force_out;
    logic              applied;
    logic              coincident;
    logic              saturated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bond_rest_reg   <= CW'(65536);
            bond_stiff_reg  <= CW'(6553600);
            cont_cutoff_reg <= CW'(65536);
            cont_stiff_reg  <= CW'(6553600);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOND_REST:   bond_rest_reg   <= cfg_data;
                REG_BOND_STIFF:  bond_stiff_reg  <= cfg_data;
                REG_CONT_CUTOFF: cont_cutoff_reg <= cfg_data;
                REG_CONT_STIFF:  cont_stiff_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign first_pos  = s_tdata[95:0];
    assign second_pos = s_tdata[191:96];

    spf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (s_tvalid),
        .req_type       (s_tuser),
        .first_pos      (first_pos),
        .second_pos     (second_pos),
        .contact_cutoff (cont_cutoff_reg),
        .out_valid      (f_valid),
        .sum_sq         (f_sum),
        .side           (f_side)
    );

    spf_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  (f_sum),
        .in_side   (f_side),
        .out_valid (r_valid),
        .root      (r_root),
        .out_side  (r_side)
    );

    assign sel_k   = r_side.contact ? cont_stiff_reg  : bond_stiff_reg;
    assign sel_len = r_side.contact ? cont_cutoff_reg : bond_rest_reg;

    spf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .root      (r_root),
        .stiffness (sel_k),
        .length    (sel_len),
        .in_side   (r_side),
        .out_valid (d_valid),
        .quotient  (d_quot),
        .out_side  (d_side)
    );

    spf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (d_valid),
        .scale      (d_quot),
        .in_side    (d_side),
        .out_valid  (m_tvalid),
        .force_out  (force_out),
        .applied    (applied),
        .coincident (coincident),
        .saturated  (saturated)
    );

    assign m_tdata = force_out;
    assign m_tuser = {saturated, coincident, applied};

endmodule
